FILE: design/tga_rle_pixel_decoder_macros.svh
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define TGA_RLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tga_rle assertion failed");

// Check that cons holds in the cycle after ante.
`define TGA_RLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tga_rle assertion failed");

`endif

FILE: design/tga_rle_pkg.sv
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder: package
// Payload types, register indexes and shared constants.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_RUN_LENGTH_MODE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BYTES_PER_PIXEL = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH     = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT    = 4'd3;

  // Pixel size code that selects BGRA; any other code means BGR
  localparam logic [2:0] BPP_FOUR  = 3'd4;
  localparam logic [2:0] BPP_THREE = 3'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       last_pixel;
  } out_item_t;

  // Completed pixel as stored: first two or three bytes plus the closing byte
  typedef struct packed {
    logic [23:0] partial;
    logic [7:0]  closing_byte;
    logic        four_bytes;
    logic [7:0]  repeat_count;
    logic        last_pixel;
  } pix_entry_t;

endpackage

FILE: design/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder: top level
// Bytes of TGA pixel data come in on the input channel (in_valid_i,
// in_ready_o, in_item_i), one per request, with start_of_image marking the
// first byte of an image. Each completed pixel leaves on the output channel
// (out_valid_o, out_ready_i, out_item_o) as RGBA with a repeat count and a
// last-pixel flag. Registers are to be written through cfg_we_i, cfg_index_i
// and cfg_data_i only while the block is idle; the block itself does not
// enforce this. One byte is accepted every cycle while the queue is not
// full. The front end classifies each byte and writes a completed pixel into
// the queue when its closing byte is accepted; the output register takes it
// from the queue once the register is empty or being taken. The byte
// classifier and pixel counter set the rate. Header and leading pixel
// bytes give no result. A stalled receiver fills the output register and
// then the pixel queue; in_ready_o drops only when the queue is full, and
// rises again as soon as the output register is taken.
// Reset clears the queue, the output valid flag and all decoder state, and
// sets the registers to uncompressed, three bytes per pixel, a 0 by 0 image.
// ----------------------------------------------------------------------------
`include "tga_rle_pixel_decoder_macros.svh"

module tga_rle_pixel_decoder #(
  parameter int unsigned QueueDepth = tga_rle_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tga_rle_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  tga_rle_pkg::in_item_t               in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tga_rle_pkg::out_item_t              out_item_o
);

  localparam int unsigned QCntW = $clog2(QueueDepth + 1);

  logic                    accept;
  logic                    q_push, q_pop, q_valid, q_full;
  logic [QCntW-1:0]        q_count;
  tga_rle_pkg::pix_entry_t push_entry, head_entry;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  // Classify bytes and build pixels
  tga_rle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_item_i   (in_item_i),
    .push_o      (q_push),
    .entry_o     (push_entry)
  );

  // Decouple front end from output stage
  tga_rle_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (head_entry),
    .full_o  (q_full),
    .count_o (q_count)
  );

  // Reorder and register results
  tga_rle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // A pixel is never pushed into a full queue
  `TGA_RLE_ASSERT_NOW(a_no_push_when_full, q_push, q_count != QCntW'(QueueDepth))
  // Every result covers at least one pixel
  `TGA_RLE_ASSERT_NOW(a_repeat_nonzero, out_valid_o, out_item_o.repeat_count != 8'd0)
  // The output register is only loaded from the queue
  `TGA_RLE_ASSERT_NEXT(a_no_result_from_nothing, !q_valid && !out_valid_o, !out_valid_o)

endmodule

FILE: design/tga_rle_front.sv
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder: front end
// Holds the registers, classifies each byte as packet header, pixel byte or
// closing pixel byte, tracks packets and the image pixel count, and pushes
// each completed pixel into the queue.
// ----------------------------------------------------------------------------
module tga_rle_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tga_rle_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                                accept_i,
  input  tga_rle_pkg::in_item_t               in_item_i,
  output logic                                push_o,
  output tga_rle_pkg::pix_entry_t             entry_o
);

  logic        mode_q, mode_d;
  logic [2:0]  bpp_q, bpp_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [31:0] total_q, total_d;

  logic        eh_q, eh_d;
  logic        run_q, run_d;
  logic [7:0]  left_q, left_d;
  logic [1:0]  pos_q, pos_d;
  logic [23:0] part_q, part_d;
  logic [31:0] done_q, done_d;

  logic        eh_eff, run_eff;
  logic [7:0]  left_eff, left_n;
  logic [1:0]  pos_eff, last_idx;
  logic [23:0] part_eff;
  logic [31:0] done_eff, remaining;
  logic [7:0]  rep;
  logic [7:0]  byte_in;
  logic [15:0] mul_a, mul_b;

  assign byte_in  = in_item_i.data_byte;
  assign last_idx = (bpp_q == tga_rle_pkg::BPP_FOUR) ? 2'd3 : 2'd2;

  // Start of image clears the packet state and pixel count before the byte is taken
  assign eh_eff   = in_item_i.start_of_image ? 1'b1  : eh_q;
  assign run_eff  = in_item_i.start_of_image ? 1'b0  : run_q;
  assign left_eff = in_item_i.start_of_image ? 8'd0  : left_q;
  assign pos_eff  = in_item_i.start_of_image ? 2'd0  : pos_q;
  assign part_eff = in_item_i.start_of_image ? 24'd0 : part_q;
  assign done_eff = in_item_i.start_of_image ? 32'd0 : done_q;

  assign remaining = total_q - done_eff;

  // Operands of the image size product, taking the word being written
  assign mul_a = (cfg_index_i == tga_rle_pkg::CFG_IMAGE_WIDTH)  ? cfg_data_i : width_q;
  assign mul_b = (cfg_index_i == tga_rle_pkg::CFG_IMAGE_HEIGHT) ? cfg_data_i : height_q;

  // Next state of registers and decoder
  always_comb begin
    mode_d   = mode_q;
    bpp_d    = bpp_q;
    width_d  = width_q;
    height_d = height_q;
    total_d  = total_q;
    eh_d     = eh_q;
    run_d    = run_q;
    left_d   = left_q;
    pos_d    = pos_q;
    part_d   = part_q;
    done_d   = done_q;
    left_n   = left_eff;
    rep      = 8'd1;
    push_o   = 1'b0;
    entry_o  = '0;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        tga_rle_pkg::CFG_RUN_LENGTH_MODE: begin
          mode_d = cfg_data_i[0];
          eh_d   = 1'b1;
          run_d  = 1'b0;
          left_d = 8'd0;
          pos_d  = 2'd0;
          part_d = 24'd0;
        end
        tga_rle_pkg::CFG_BYTES_PER_PIXEL: begin
          bpp_d  = cfg_data_i[2:0];
          eh_d   = 1'b1;
          run_d  = 1'b0;
          left_d = 8'd0;
          pos_d  = 2'd0;
          part_d = 24'd0;
        end
        tga_rle_pkg::CFG_IMAGE_WIDTH: begin
          width_d = cfg_data_i;
          total_d = mul_a * mul_b;
        end
        tga_rle_pkg::CFG_IMAGE_HEIGHT: begin
          height_d = cfg_data_i;
          total_d  = mul_a * mul_b;
        end
        default: ;
      endcase
    end else if (accept_i) begin
      eh_d   = eh_eff;
      run_d  = run_eff;
      left_d = left_eff;
      pos_d  = pos_eff;
      part_d = part_eff;
      done_d = done_eff;

      // Drop bytes once the image is complete
      if (done_eff < total_q) begin
        if (mode_q && eh_eff) begin
          // Packet header: run flag and pixel count
          run_d  = byte_in[7];
          left_d = {1'b0, byte_in[6:0]} + 8'd1;
          eh_d   = 1'b0;
          pos_d  = 2'd0;
        end else if (pos_eff < last_idx) begin
          // Collect a stored byte of the pixel
          case (pos_eff)
            2'd0:    part_d = {part_eff[23:8], byte_in};
            2'd1:    part_d = {part_eff[23:16], byte_in, part_eff[7:0]};
            default: part_d = {byte_in, part_eff[15:0]};
          endcase
          pos_d = pos_eff + 2'd1;
        end else begin
          // Closing byte: settle repeat count and packet progress
          if (mode_q) begin
            if (run_eff) begin
              rep    = (left_eff == 8'd0) ? 8'd1 : left_eff;
              left_n = 8'd0;
            end else if (left_eff != 8'd0) begin
              left_n = left_eff - 8'd1;
            end
            if (left_n == 8'd0) begin
              eh_d = 1'b1;
            end
          end
          left_d = left_n;
          if ({24'd0, rep} > remaining) begin
            rep = remaining[7:0];
          end
          done_d = done_eff + {24'd0, rep};
          push_o = 1'b1;
          entry_o.partial      = part_eff;
          entry_o.closing_byte = byte_in;
          entry_o.four_bytes   = (bpp_q == tga_rle_pkg::BPP_FOUR);
          entry_o.repeat_count = rep;
          entry_o.last_pixel   = (done_d == total_q);
          pos_d  = 2'd0;
          part_d = 24'd0;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      bpp_q    <= tga_rle_pkg::BPP_THREE;
      width_q  <= 16'd0;
      height_q <= 16'd0;
      total_q  <= 32'd0;
      eh_q     <= 1'b1;
      run_q    <= 1'b0;
      left_q   <= 8'd0;
      pos_q    <= 2'd0;
      part_q   <= 24'd0;
      done_q   <= 32'd0;
    end else begin
      mode_q   <= mode_d;
      bpp_q    <= bpp_d;
      width_q  <= width_d;
      height_q <= height_d;
      total_q  <= total_d;
      eh_q     <= eh_d;
      run_q    <= run_d;
      left_q   <= left_d;
      pos_q    <= pos_d;
      part_q   <= part_d;
      done_q   <= done_d;
    end
  end

endmodule

FILE: design/tga_rle_fifo.sv
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder: pixel queue
// Short first-in first-out queue of completed pixels between the front end
// and the output stage. Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module tga_rle_fifo #(
  parameter int unsigned Depth = tga_rle_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  tga_rle_pkg::pix_entry_t          entry_i,
  input  logic                             pop_i,
  output logic                             valid_o,
  output tga_rle_pkg::pix_entry_t          entry_o,
  output logic                             full_o,
  output logic [$clog2(Depth+1)-1:0]       count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tga_rle_pkg::pix_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign count_o = cnt_q;
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: design/tga_rle_back.sv
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder: output stage
// Takes pixels from the queue, swaps stored BGR(A) order to RGBA and holds
// the result in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module tga_rle_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  tga_rle_pkg::pix_entry_t q_entry_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output tga_rle_pkg::out_item_t  out_item_o
);

  logic                   valid_q;
  tga_rle_pkg::out_item_t item_q, item_d;

  assign q_pop_o     = q_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  // Reorder to RGBA; alpha is zero for three-byte pixels
  always_comb begin
    item_d.green        = q_entry_i.partial[15:8];
    item_d.blue         = q_entry_i.partial[7:0];
    item_d.repeat_count = q_entry_i.repeat_count;
    item_d.last_pixel   = q_entry_i.last_pixel;
    if (q_entry_i.four_bytes) begin
      item_d.red   = q_entry_i.partial[23:16];
      item_d.alpha = q_entry_i.closing_byte;
    end else begin
      item_d.red   = q_entry_i.closing_byte;
      item_d.alpha = 8'd0;
    end
  end

  // Load the payload register on pop
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= item_d;
    end
  end

  // Hold valid until the receiver takes the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule
